// File: sv/lat_pkg.sv
// Shared types, constants and tables for the LoRa airtime calculator.
package lat_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BITS_W     = 11;
  localparam int unsigned RECIP_W    = 14;
  localparam int unsigned RECIP_SH   = 16;
  localparam int unsigned X_W        = 10;
  localparam int unsigned BLK_W      = 7;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_SF  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CR  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PRE = 3'd4;

  localparam logic [1:0] BW_125 = 2'd0;
  localparam logic [1:0] BW_250 = 2'd1;
  localparam logic [1:0] BW_500 = 2'd2;

  localparam logic [3:0] SF_MIN = 4'd7;
  localparam logic [3:0] SF_MAX = 4'd12;
  localparam logic [2:0] CR_MIN = 3'd1;
  localparam logic [2:0] CR_MAX = 3'd4;

  // Normalised configuration as seen by the datapath
  typedef struct packed {
    logic [3:0]         sf;
    logic [3:0]         ts_exp;  // log2 of symbol time in us
    logic [3:0]         k;       // SF - 2, block divisor is 4k
    logic [RECIP_W-1:0] recip;   // ceil(2^16 / k)
    logic [3:0]         cr4;     // CR + 4
    logic               implicit_hdr;
    logic [31:0]        pre_us;
  } cfg_t;

  // Coded block counts with and without the header term
  typedef struct packed {
    logic [BLK_W-1:0] c_exp;
    logic [BLK_W-1:0] c_imp;
  } blk_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd5:    r = 14'd13108;
      4'd6:    r = 14'd10923;
      4'd7:    r = 14'd9363;
      4'd8:    r = 14'd8192;
      4'd9:    r = 14'd7282;
      4'd10:   r = 14'd6554;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/lat_in_if.sv
// Input channel: payload length transactions.
interface lat_in_if;
  logic                            valid;
  logic                            ready;
  logic [lat_pkg::BITS_W-1:0]      payload_bits;

  modport source (output valid, output payload_bits, input ready);
  modport sink   (input valid, input payload_bits, output ready);
endinterface

// File: sv/lat_out_if.sv
// Result channel: airtime transactions.
interface lat_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_us;
  logic [31:0] preamble_us;
  logic [15:0] header_us;
  logic [22:0] payload_us;
  logic [9:0]  payload_symbol_count;

  modport source (output valid, output total_us, output preamble_us, output header_us,
                  output payload_us, output payload_symbol_count, input ready);
  modport sink   (input valid, input total_us, input preamble_us, input header_us,
                  input payload_us, input payload_symbol_count, output ready);
endinterface

// File: sv/lat_cfg.sv
// Configuration registers and their normalisation into the datapath view.
module lat_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lat_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lat_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lat_pkg::cfg_t                     cfg
);

  logic [3:0]  sf_r;
  logic [1:0]  bw_r;
  logic [2:0]  cr_r;
  logic        imp_r;
  logic [15:0] pre_r;

  logic [3:0]  sf_n;
  logic [2:0]  cr_n;
  logic [3:0]  ts_exp;
  logic [18:0] pre_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r  <= 4'd7;
      bw_r  <= 2'd0;
      cr_r  <= 3'd1;
      imp_r <= 1'b0;
      pre_r <= 16'd8;
    end else if (cfg_we) begin
      case (cfg_addr)
        lat_pkg::REG_SF:  sf_r  <= cfg_wdata[3:0];
        lat_pkg::REG_BW:  bw_r  <= cfg_wdata[1:0];
        lat_pkg::REG_CR:  cr_r  <= cfg_wdata[2:0];
        lat_pkg::REG_IMP: imp_r <= cfg_wdata[0];
        lat_pkg::REG_PRE: pre_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sf_r < lat_pkg::SF_MIN)      sf_n = lat_pkg::SF_MIN;
    else if (sf_r > lat_pkg::SF_MAX) sf_n = lat_pkg::SF_MAX;
    else                             sf_n = sf_r;

    if (cr_r < lat_pkg::CR_MIN)      cr_n = lat_pkg::CR_MIN;
    else if (cr_r > lat_pkg::CR_MAX) cr_n = lat_pkg::CR_MAX;
    else                             cr_n = cr_r;

    // Ts = 2^SF * {8,4,2}; code three behaves as 500 kHz
    if (bw_r == lat_pkg::BW_125)      ts_exp = sf_n + 4'd3;
    else if (bw_r == lat_pkg::BW_250) ts_exp = sf_n + 4'd2;
    else                              ts_exp = sf_n + 4'd1;

    // (P + 4.25) * Ts = (4P + 17) * Ts/4
    pre_q = {1'b0, pre_r, 2'b00} + 19'd17;

    cfg.sf           = sf_n;
    cfg.ts_exp       = ts_exp;
    cfg.k            = sf_n - 4'd2;
    cfg.recip        = lat_pkg::recip_of(sf_n - 4'd2);
    cfg.cr4          = {1'b0, cr_n} + 4'd4;
    cfg.implicit_hdr = imp_r;
    cfg.pre_us       = {13'd0, pre_q} << (ts_exp - 4'd2);
  end

endmodule

// File: sv/lat_div.sv
// Two pipeline stages: block numerators, then reciprocal division into coded blocks.
module lat_div (
  input  logic           clk,
  input  logic           rst_n,
  input  lat_pkg::cfg_t  cfg,
  lat_in_if.sink         in_ch,
  output logic           blk_valid,
  input  logic           blk_ready,
  output lat_pkg::blk_t  blk
);

  logic                      v1_r, v1_nxt;
  logic                      v2_r, v2_nxt;
  logic                      en1, en2;
  logic [lat_pkg::X_W-1:0]   x_exp_r, x_exp_nxt;
  logic [lat_pkg::X_W-1:0]   x_imp_r, x_imp_nxt;
  lat_pkg::blk_t             blk_r, blk_nxt;
  logic [11:0]               t;
  logic [23:0]               prod_exp, prod_imp;

  // ceil(num / 4k) = floor((ceil(num/4) + k - 1) / k), zero when num <= 0
  function automatic logic [lat_pkg::X_W-1:0] blk_x(input logic [11:0] tv,
                                                    input logic [6:0]  sub,
                                                    input logic [3:0]  k);
    logic [11:0] d;
    logic [9:0]  m;
    d = tv - {5'd0, sub} + 12'd3;
    m = d[11:2];
    if (tv > {5'd0, sub}) return m + {6'd0, k} - 10'd1;
    else                  return '0;
  endfunction

  assign en2         = !v2_r || blk_ready;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign blk_valid   = v2_r;
  assign blk         = blk_r;

  always_comb begin
    t         = {1'b0, in_ch.payload_bits} + 12'd44;
    x_exp_nxt = blk_x(t, {1'b0, cfg.sf, 2'b00}, cfg.k);
    x_imp_nxt = blk_x(t, {1'b0, cfg.sf, 2'b00} + 7'd20, cfg.k);
    v1_nxt    = en1 ? in_ch.valid : v1_r;
    v2_nxt    = en2 ? v1_r : v2_r;
    prod_exp  = {14'd0, x_exp_r} * {10'd0, cfg.recip};
    prod_imp  = {14'd0, x_imp_r} * {10'd0, cfg.recip};
    blk_nxt.c_exp = prod_exp[lat_pkg::RECIP_SH +: lat_pkg::BLK_W];
    blk_nxt.c_imp = prod_imp[lat_pkg::RECIP_SH +: lat_pkg::BLK_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      x_exp_r <= x_exp_nxt;
      x_imp_r <= x_imp_nxt;
    end
    if (en2 && v1_r) begin
      blk_r <= blk_nxt;
    end
  end

  a_exp_ge_imp: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> blk_r.c_exp >= blk_r.c_imp)
    else $error("header-free block count exceeds full count");

  a_hdr_one_blk: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (blk_r.c_exp - blk_r.c_imp) <= 7'd1)
    else $error("header term spans more than one block");

  a_imp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && x_exp_r == '0) |-> x_imp_r == '0)
    else $error("implicit numerator positive while explicit is not");

endmodule

// File: sv/lat_sum.sv
// Two pipeline stages: symbol count and shares, then total and output register.
module lat_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  lat_pkg::cfg_t  cfg,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  lat_pkg::blk_t  blk,
  lat_out_if.source      out_ch
);

  logic        v3_r, v3_nxt;
  logic        v4_r, v4_nxt;
  logic        en3, en4;
  logic [9:0]  cnt_r, cnt_nxt;
  logic [15:0] hdr_r, hdr_nxt;
  logic [22:0] pay_r, pay_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] pre_r;
  logic [9:0]  cnt4_r;
  logic [15:0] hdr4_r;
  logic [22:0] pay4_r;
  logic [6:0]  c_sel;
  logic [10:0] coded;

  assign en4       = !v4_r || out_ch.ready;
  assign en3       = !v3_r || en4;
  assign blk_ready = en3;

  always_comb begin
    c_sel   = cfg.implicit_hdr ? blk.c_imp : blk.c_exp;
    coded   = {4'd0, c_sel} * {7'd0, cfg.cr4};
    cnt_nxt = coded[9:0] + 10'd8;
    // explicit header adds at most one symbol time
    hdr_nxt = (!cfg.implicit_hdr && (blk.c_exp != blk.c_imp)) ?
              (16'd1 << cfg.ts_exp) : 16'd0;
    pay_nxt   = {16'd0, blk.c_imp} << cfg.ts_exp;
    total_nxt = ({22'd0, cnt_r} << cfg.ts_exp) + cfg.pre_us;
    v3_nxt    = en3 ? blk_valid : v3_r;
    v4_nxt    = en4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && blk_valid) begin
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
      pay_r <= pay_nxt;
    end
    if (en4 && v3_r) begin
      total_r <= total_nxt;
      pre_r   <= cfg.pre_us;
      cnt4_r  <= cnt_r;
      hdr4_r  <= hdr_r;
      pay4_r  <= pay_r;
    end
  end

  assign out_ch.valid                = v4_r;
  assign out_ch.total_us             = total_r;
  assign out_ch.preamble_us          = pre_r;
  assign out_ch.header_us            = hdr4_r;
  assign out_ch.payload_us           = pay4_r;
  assign out_ch.payload_symbol_count = cnt4_r;

  a_cnt_min: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> cnt4_r >= 10'd8)
    else $error("symbol count below the fixed eight");

  a_hdr_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> $countones(hdr4_r) <= 1)
    else $error("header time is not zero or one symbol");

  a_total_ge_pre: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> total_r >= pre_r)
    else $error("total airtime below preamble time");

endmodule

// File: sv/lora_airtime_calculator.sv
// LoRa time-on-air calculator, top level.
// Usage:
//   in_ch  : one transaction per frame, carrying payload_bits (length in bits).
//   out_ch : one transaction per input, carrying total_us, preamble_us,
//            header_us, payload_us and payload_symbol_count.
//   cfg_*  : write port; cfg_addr 0..4 selects spreading factor, bandwidth
//            code, code rate, implicit header and preamble length. Write only while no
//            transaction is in flight (not enforced). Other indexes are ignored.
//            Out-of-range settings are clamped to the nearest legal.
// Timing: four register stages (numerators, reciprocal divide, symbol count
//   and shares, total). One transaction per cycle is sustained while out_ch
//   takes results; a stage takes a new transaction each edge unless it holds
//   a result that cannot move on.
// Reset clears all stage valids and loads the default configuration
//   (SF7, 125 kHz, CR 4/5, explicit header, preamble of 8).
// When out_ch stalls, results hold in their stages and empty stages keep
//   filling; in_ch.ready drops only once every stage holds a result.
module lora_airtime_calculator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lat_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lat_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  lat_in_if.sink                            in_ch,
  lat_out_if.source                         out_ch
);

  lat_pkg::cfg_t cfg;
  lat_pkg::blk_t blk;
  logic          blk_valid;
  logic          blk_ready;

  lat_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lat_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  lat_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .out_ch    (out_ch)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for the LoRa airtime calculator: directed table, then random phases.
module tb;

  localparam int IDLE_PCT         = 28;
  localparam int DRAIN_PAUSE      = 5;
  localparam int HOLD_CYCLES      = 48;
  localparam int PHASES           = 10;
  localparam int FRAMES_PER_PHASE = 125;
  localparam int WATCHDOG_TIME    = 2_000_000;

  localparam logic [lat_pkg::CFG_ADDR_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [lat_pkg::CFG_ADDR_W-1:0] REG_UNUSED       = 3'd7;

  typedef struct packed {
    logic [31:0] total_us;
    logic [31:0] preamble_us;
    logic [15:0] header_us;
    logic [22:0] payload_us;
    logic [9:0]  payload_symbol_count;
  } airtime_t;

  typedef struct packed {
    logic [3:0]  sf;
    logic [1:0]  bw;
    logic [2:0]  cr;
    logic        imp;
    logic [15:0] pre;
  } radio_regs_t;

  typedef enum logic {ROW_REG, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [lat_pkg::CFG_ADDR_W-1:0] addr;
    logic [lat_pkg::CFG_DATA_W-1:0] wdata;
    logic [lat_pkg::BITS_W-1:0]     bits;
    logic                           typed;
    airtime_t                       want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lat_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lat_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lat_in_if  in_ch ();
  lat_out_if out_ch ();

  lora_airtime_calculator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  airtime_t    airtime_q [$];
  radio_regs_t radio_regs;
  int          errors;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_req;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_TIME);
    $display("lora_airtime_calculator verification failed");
    $finish;
  end

  // Signed ceiling division, den > 0
  function automatic longint ceil_blocks(input longint num, input longint den);
    if (num >= 0) begin
      return (num + den - 1) / den;
    end
    return -((-num) / den);
  endfunction

  function automatic airtime_t predict_airtime(input logic [lat_pkg::BITS_W-1:0] bits,
                                               input radio_regs_t r);
    longint b, sf, cr, ts, pre, c_imp, c_exp, coded, count, hdr, pay;
    airtime_t a;
    b  = bits;
    sf = r.sf;
    cr = r.cr;
    if (sf < lat_pkg::SF_MIN) sf = lat_pkg::SF_MIN;
    if (sf > lat_pkg::SF_MAX) sf = lat_pkg::SF_MAX;
    if (cr < lat_pkg::CR_MIN) cr = lat_pkg::CR_MIN;
    if (cr > lat_pkg::CR_MAX) cr = lat_pkg::CR_MAX;
    ts = longint'(1) << sf;
    if (r.bw == lat_pkg::BW_125) ts = ts * 8;
    else if (r.bw == lat_pkg::BW_250) ts = ts * 4;
    else ts = ts * 2;
    // 4.25 sync symbols: ts is a multiple of 4
    pre   = ts * longint'(r.pre) + 17 * (ts / 4);
    c_imp = ceil_blocks(b - 4 * sf + 44 - 20, 4 * (sf - 2));
    c_exp = ceil_blocks(b - 4 * sf + 44, 4 * (sf - 2));
    coded = (r.imp ? c_imp : c_exp) * (cr + 4);
    if (coded < 0) coded = 0;
    count = 8 + coded;
    hdr   = r.imp ? 0 : (c_exp - c_imp) * ts;
    pay   = (c_imp > 0) ? c_imp * ts : 0;
    a.total_us             = 32'(ts * count + pre);
    a.preamble_us          = 32'(pre);
    a.header_us            = 16'(hdr);
    a.payload_us           = 23'(pay);
    a.payload_symbol_count = 10'(count);
    return a;
  endfunction

  function automatic stim_row_t reg_row(input logic [lat_pkg::CFG_ADDR_W-1:0] addr,
                                        input logic [lat_pkg::CFG_DATA_W-1:0] wdata);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.addr  = addr;
    r.wdata = wdata;
    r.bits  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t frame_row(input logic [lat_pkg::BITS_W-1:0] bits);
    stim_row_t r;
    r       = reg_row(lat_pkg::REG_SF, '0);
    r.kind  = ROW_FRAME;
    r.bits  = bits;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [lat_pkg::BITS_W-1:0] bits,
                                            input logic [31:0] total,
                                            input logic [31:0] pre,
                                            input logic [15:0] hdr,
                                            input logic [22:0] pay,
                                            input logic [9:0]  cnt);
    stim_row_t r;
    r       = frame_row(bits);
    r.typed = 1'b1;
    r.want  = '{total, pre, hdr, pay, cnt};
    return r;
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    errors++;
  endtask

  // Writes only with the pipeline empty
  task automatic write_reg(input logic [lat_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [lat_pkg::CFG_DATA_W-1:0] wdata);
    in_ch.valid <= 1'b0;
    while (airtime_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      lat_pkg::REG_SF:  radio_regs.sf  = wdata[3:0];
      lat_pkg::REG_BW:  radio_regs.bw  = wdata[1:0];
      lat_pkg::REG_CR:  radio_regs.cr  = wdata[2:0];
      lat_pkg::REG_IMP: radio_regs.imp = wdata[0];
      lat_pkg::REG_PRE: radio_regs.pre = wdata;
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [lat_pkg::BITS_W-1:0] bits, input logic typed,
                            input airtime_t want);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_bits <= bits;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    airtime_q.push_back(typed ? want : predict_airtime(bits, radio_regs));
  endtask

  // Result side: random back-pressure, plus a long hold when asked for
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    airtime_t want;
    airtime_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.total_us, out_ch.preamble_us, out_ch.header_us,
              out_ch.payload_us, out_ch.payload_symbol_count};
      if (airtime_q.size() == 0) begin
        $display("%0t: result transaction with nothing outstanding, expected none got %0d",
                 $time, got.total_us);
        errors++;
      end else begin
        want = airtime_q.pop_front();
        if (got.total_us !== want.total_us)
          report_field("total_us", want.total_us, got.total_us);
        if (got.preamble_us !== want.preamble_us)
          report_field("preamble_us", want.preamble_us, got.preamble_us);
        if (got.header_us !== want.header_us)
          report_field("header_us", want.header_us, got.header_us);
        if (got.payload_us !== want.payload_us)
          report_field("payload_us", want.payload_us, got.payload_us);
        if (got.payload_symbol_count !== want.payload_symbol_count)
          report_field("payload_symbol_count", want.payload_symbol_count,
                       got.payload_symbol_count);
      end
    end
  end

  initial begin
    stim_row_t                      directed_rows [$];
    logic [lat_pkg::CFG_DATA_W-1:0] wd;
    logic [lat_pkg::BITS_W-1:0]     bits;
    errors     = 0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    hold_req   = 1'b0;
    hold_left  = 0;
    radio_regs = '{4'd7, lat_pkg::BW_125, 3'd1, 1'b0, 16'd8};

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_addr           <= lat_pkg::REG_SF;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_bits <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_rows = {
      // reset defaults: SF7, 125 kHz, CR 4/5, explicit, 8 preamble symbols
      checked_row(11'd0, 32'd25856, 32'd12544, 16'd1024, 23'd0, 10'd13),
      checked_row(11'd2047, 32'd553216, 32'd12544, 16'd1024, 23'd105472, 10'd528),
      frame_row(11'h555), frame_row(11'h2AA), frame_row(11'd4), frame_row(11'd5),
      // implicit header, empty payload clamps to zero coded symbols
      reg_row(lat_pkg::REG_IMP, 16'd1),
      checked_row(11'd0, 32'd20736, 32'd12544, 16'd0, 23'd0, 10'd8),
      // SF below range saturates to 7
      reg_row(lat_pkg::REG_SF, 16'd0), frame_row(11'd100),
      reg_row(lat_pkg::REG_SF, 16'd6), frame_row(11'd1999),
      // everything at the top: SF over range, bandwidth code three, CR over range
      reg_row(lat_pkg::REG_SF, 16'd13), reg_row(lat_pkg::REG_BW, 16'd3),
      reg_row(lat_pkg::REG_CR, 16'd7),
      reg_row(lat_pkg::REG_PRE, 16'hFFFF),
      checked_row(11'd2047, 32'd540305408, 32'd536897536, 16'd0, 23'd417792, 10'd416),
      checked_row(11'd0, 32'd536963072, 32'd536897536, 16'd0, 23'd0, 10'd8),
      // unused register index must not disturb anything
      reg_row(REG_UNUSED, 16'hFFFF), frame_row(11'd1000),
      reg_row(lat_pkg::REG_CR, 16'd0), reg_row(lat_pkg::REG_BW, 16'(lat_pkg::BW_250)),
      reg_row(lat_pkg::REG_PRE, 16'd0),
      reg_row(lat_pkg::REG_IMP, 16'd0), reg_row(lat_pkg::REG_SF, 16'd12),
      frame_row(11'd2047), frame_row(11'd0),
      reg_row(lat_pkg::REG_BW, 16'(lat_pkg::BW_500)), reg_row(lat_pkg::REG_CR, 16'd2),
      frame_row(11'd700),
      reg_row(lat_pkg::REG_CR, 16'd3), reg_row(lat_pkg::REG_SF, 16'd8), frame_row(11'd333),
      reg_row(lat_pkg::REG_SF, 16'd9), frame_row(11'd1234),
      reg_row(lat_pkg::REG_SF, 16'd10), reg_row(lat_pkg::REG_CR, 16'd4), frame_row(11'd64),
      reg_row(lat_pkg::REG_SF, 16'd11), frame_row(11'd1500)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].addr, directed_rows[i].wdata);
      else
        send_frame(directed_rows[i].bits, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        write_reg(lat_pkg::REG_SF, 16'(lat_pkg::SF_MIN));
        write_reg(lat_pkg::REG_BW, 16'(lat_pkg::BW_125));
        write_reg(lat_pkg::REG_CR, 16'(lat_pkg::CR_MIN));
        write_reg(lat_pkg::REG_IMP, 16'd0);
        write_reg(lat_pkg::REG_PRE, 16'd0);
      end else if (p == 1) begin
        write_reg(lat_pkg::REG_SF, 16'(lat_pkg::SF_MAX));
        write_reg(lat_pkg::REG_BW, 16'(lat_pkg::BW_500));
        write_reg(lat_pkg::REG_CR, 16'(lat_pkg::CR_MAX));
        write_reg(lat_pkg::REG_IMP, 16'd1);
        write_reg(lat_pkg::REG_PRE, 16'hFFFF);
      end else begin
        // random upper bits check that only the field width is kept
        wd = 16'($urandom);
        wd[3:0] = ($urandom_range(99) < 70) ?
                  4'($urandom_range(lat_pkg::SF_MAX, lat_pkg::SF_MIN)) :
                  4'($urandom_range(15));
        write_reg(lat_pkg::REG_SF, wd);
        wd = 16'($urandom);
        write_reg(lat_pkg::REG_BW, wd);
        wd = 16'($urandom);
        write_reg(lat_pkg::REG_CR, wd);
        wd = 16'($urandom);
        write_reg(lat_pkg::REG_IMP, wd);
        wd = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(16));
        write_reg(lat_pkg::REG_PRE, wd);
        write_reg(3'($urandom_range(REG_UNUSED, REG_FIRST_UNUSED)), 16'($urandom));
      end

      tx_steady = (p == 1 || p == 2 || p == 6);
      rx_steady = (p == 2);
      // long hold on the result side while frames keep coming
      if (p == 1 || p == 6) hold_req = 1'b1;

      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        bits = ($urandom_range(99) < 80) ? 11'($urandom_range(2047))
                                         : 11'($urandom_range(80));
        send_frame(bits, 1'b0, '0);
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    while (airtime_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("lora_airtime_calculator verification clean");
    end else begin
      $display("lora_airtime_calculator verification failed");
    end
    $finish;
  end

endmodule
